### src/sdspi_pkg.sv
// Shared types, codes and helper functions for the SD SPI command engine.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sdspi_pkg;

	localparam logic [1:0] MODE_REQ  = 2'd0;
	localparam logic [1:0] MODE_RX   = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	localparam logic [1:0] CFG_READY_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_RETRY_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_POLL_LIMIT    = 2'd2;

	localparam logic [5:0] CMD_STOP = 6'd12;
	localparam logic [5:0] CMD_APP  = 6'd55;

	localparam logic [7:0] FILL_BYTE  = 8'hFF;
	localparam logic [7:0] START_BITS = 8'h40;
	localparam logic [7:0] CRC_POLY   = 8'h89;
	localparam logic [2:0] CRC_POS    = 3'd5;

	localparam logic [15:0] READY_TIMEOUT_RST = 16'd2000;
	localparam logic [2:0]  RETRY_LIMIT_RST   = 3'd3;
	localparam logic [7:0]  POLL_LIMIT_RST    = 8'd16;

	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_READY1 = 3'd1,
		PH_SEND   = 3'd2,
		PH_STUFF  = 3'd3,
		PH_POLL   = 3'd4,
		PH_READY2 = 3'd5
	} phase_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [5:0]  cmd_index;
		logic [31:0] argument;
		logic        app_command;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic [7:0] r1_response;
		logic       no_response;
	} rsp_t;

	typedef struct packed {
		logic [15:0] ready_timeout_ticks;
		logic [2:0]  retry_limit;
		logic [7:0]  poll_limit;
	} cfg_t;

	function automatic logic [6:0] crc7_step(input logic [6:0] crc, input logic [7:0] b);
		logic [7:0] x;
		x = {crc, 1'b0} ^ b;
		if (x[7]) x = x ^ CRC_POLY;
		for (int i = 0; i < 7; i++) begin
			x = {x[6:0], 1'b0};
			if (x[7]) x = x ^ CRC_POLY;
		end
		return x[6:0];
	endfunction

	function automatic logic [7:0] pkt_byte(input logic [2:0] pos, input logic prefix,
		input logic [5:0] idx, input logic [31:0] arg, input logic [6:0] crc);
		logic [5:0]  cmd;
		logic [31:0] a;
		logic [7:0]  b;
		cmd = prefix ? CMD_APP : idx;
		a   = prefix ? 32'd0 : arg;
		case (pos)
			3'd0:    b = START_BITS | {2'b00, cmd};
			3'd1:    b = a[31:24];
			3'd2:    b = a[23:16];
			3'd3:    b = a[15:8];
			3'd4:    b = a[7:0];
			default: b = {crc, 1'b1};
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

### src/sdspi_cfg.sv
// Configuration registers of the SD SPI command engine: timeout, retries, poll limit.
// Depends on sdspi_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module sdspi_cfg (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_write,
	input  wire [1:0]         cfg_index,
	input  wire [15:0]        cfg_data,
	output sdspi_pkg::cfg_t   cfg
);
	import sdspi_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_timeout_ticks <= READY_TIMEOUT_RST;
			cfg_q.retry_limit         <= RETRY_LIMIT_RST;
			cfg_q.poll_limit          <= POLL_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_READY_TIMEOUT: cfg_q.ready_timeout_ticks <= cfg_data;
				CFG_RETRY_LIMIT:   cfg_q.retry_limit         <= cfg_data[2:0];
				CFG_POLL_LIMIT:    cfg_q.poll_limit          <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/sdspi_fsm.sv
// Command sequencer: ready wait, packet send with CRC7, stuff byte, R1 poll, retry.
// Depends on sdspi_pkg for phase_t, req_t, rsp_t, cfg_t and the CRC helpers.
`timescale 1ns / 1ps
`default_nettype none

module sdspi_fsm (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               en,
	input  sdspi_pkg::req_t   item,
	input  sdspi_pkg::cfg_t   cfg,
	output logic              emit,
	output sdspi_pkg::rsp_t   res
);
	import sdspi_pkg::*;

	phase_t      phase_q, phase_d;
	logic [5:0]  idx_q, idx_d;
	logic [31:0] arg_q, arg_d;
	logic        app_q, app_d;
	logic        pre_q, pre_d;
	logic [2:0]  pos_q, pos_d;
	logic [7:0]  poll_q, poll_d;
	logic [2:0]  retry_q, retry_d;
	logic [15:0] ticks_q, ticks_d;
	logic [6:0]  crc_q, crc_d;

	logic        do_pkt;
	logic        pkt_pre;
	logic [2:0]  pkt_pos;
	logic [6:0]  pkt_crc;
	logic [7:0]  pkt_b;
	logic [7:0]  poll_inc;
	logic [2:0]  retry_inc;
	logic [2:0]  lim;
	logic [5:0]  cur_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			arg_q   <= '0;
			app_q   <= 1'b0;
			pre_q   <= 1'b0;
			pos_q   <= '0;
			poll_q  <= '0;
			retry_q <= '0;
			ticks_q <= '0;
			crc_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			arg_q   <= arg_d;
			app_q   <= app_d;
			pre_q   <= pre_d;
			pos_q   <= pos_d;
			poll_q  <= poll_d;
			retry_q <= retry_d;
			ticks_q <= ticks_d;
			crc_q   <= crc_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		arg_d   = arg_q;
		app_d   = app_q;
		pre_d   = pre_q;
		pos_d   = pos_q;
		poll_d  = poll_q;
		retry_d = retry_q;
		ticks_d = ticks_q;
		crc_d   = crc_q;
		do_pkt  = 1'b0;
		pkt_pre = pre_q;
		pkt_pos = 3'd0;
		pkt_crc = 7'd0;
		emit    = 1'b0;
		res     = '{kind: KIND_TX, tx_byte: FILL_BYTE, r1_response: 8'd0, no_response: 1'b0};

		poll_inc  = poll_q + 8'd1;
		retry_inc = retry_q + 3'd1;
		lim       = (cfg.retry_limit == 3'd0) ? 3'd1 : cfg.retry_limit;
		cur_cmd   = pre_q ? CMD_APP : idx_q;

		case (item.mode)
			MODE_TICK: begin
				if (ticks_q != 16'hFFFF) ticks_d = ticks_q + 16'd1;
			end
			MODE_REQ: begin
				if (phase_q == PH_IDLE) begin
					idx_d   = item.cmd_index;
					arg_d   = item.argument;
					app_d   = item.app_command;
					retry_d = 3'd0;
					pre_d   = 1'b0;
					if (item.cmd_index != CMD_STOP) begin
						phase_d = PH_READY1;
						ticks_d = 16'd0;
						emit    = 1'b1;
					end else begin
						do_pkt  = 1'b1;
						pkt_pre = item.app_command;
					end
				end
			end
			MODE_RX: begin
				case (phase_q)
					PH_READY1, PH_READY2: begin
						if (item.rx_byte == 8'd0 && ticks_q < cfg.ready_timeout_ticks) begin
							emit = 1'b1;
						end else begin
							do_pkt  = 1'b1;
							pkt_pre = (phase_q == PH_READY1) ? app_q : 1'b0;
						end
					end
					PH_SEND: begin
						if (pos_q < CRC_POS) begin
							do_pkt  = 1'b1;
							pkt_pre = pre_q;
							pkt_pos = pos_q + 3'd1;
							pkt_crc = crc_q;
						end else begin
							poll_d  = 8'd0;
							phase_d = (cur_cmd == CMD_STOP) ? PH_STUFF : PH_POLL;
							emit    = 1'b1;
						end
					end
					PH_STUFF: begin
						phase_d = PH_POLL;
						poll_d  = 8'd0;
						emit    = 1'b1;
					end
					PH_POLL: begin
						poll_d = poll_inc;
						if (!item.rx_byte[7] || poll_inc >= cfg.poll_limit) begin
							if (pre_q) begin
								pre_d   = 1'b0;
								phase_d = PH_READY2;
								ticks_d = 16'd0;
								emit    = 1'b1;
							end else if (item.rx_byte != FILL_BYTE) begin
								phase_d = PH_IDLE;
								emit    = 1'b1;
								res     = '{kind: KIND_DONE, tx_byte: 8'd0,
									r1_response: item.rx_byte, no_response: 1'b0};
							end else begin
								retry_d = retry_inc;
								if (retry_inc < lim) begin
									do_pkt  = 1'b1;
									pkt_pre = app_q;
								end else begin
									phase_d = PH_IDLE;
									emit    = 1'b1;
									res     = '{kind: KIND_DONE, tx_byte: 8'd0,
										r1_response: FILL_BYTE, no_response: 1'b1};
								end
							end
						end else begin
							emit = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		pkt_b = pkt_byte(pkt_pos, pkt_pre, idx_d, arg_d, pkt_crc);
		if (do_pkt) begin
			phase_d = PH_SEND;
			pre_d   = pkt_pre;
			pos_d   = pkt_pos;
			crc_d   = (pkt_pos < CRC_POS) ? crc7_step(pkt_crc, pkt_b) : pkt_crc;
			emit    = 1'b1;
			res     = '{kind: KIND_TX, tx_byte: pkt_b, r1_response: 8'd0, no_response: 1'b0};
		end
	end

endmodule

`default_nettype wire

### src/sd_spi_command_engine_top.sv
// Top level of the SD SPI command engine: input register, sequencer, result register.
// Depends on sdspi_pkg, sdspi_cfg and sdspi_fsm.
//
// Usage:
//   req channel (req_valid, req_stall, req): one item per request; mode selects a
//   command request, a byte received from the card, or one timer tick.
//   rsp channel (rsp_valid, rsp_stall, rsp): either a byte to send to the card
//   (kind 0) or the end of a command with its R1 byte (kind 1).
//   cfg_write/cfg_index/cfg_data write the timeout, retry and poll registers;
//   write them only while no command is in flight.
// Path: a request is held in the input register, the sequencer computes its result
//   combinationally, and the result register captures it on the same edge at which
//   the sequencer state updates.
// Throughput: one request per cycle while rsp_stall is low.
// Reset: arst_n clears both registers' valid flags, returns the sequencer to idle
//   and loads the register reset values (timeout 2000, retries 3, poll 16).
// Stall: while a result is held and rsp_stall is high, the input register holds
//   its request and req_stall rises until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_command_engine_top (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  sdspi_pkg::req_t   req,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output sdspi_pkg::rsp_t   rsp,
	input  wire               cfg_write,
	input  wire [1:0]         cfg_index,
	input  wire [15:0]        cfg_data
);
	import sdspi_pkg::*;

	req_t req_s1;
	logic req_valid_s1;
	rsp_t rsp_q;
	logic rsp_valid_q;
	cfg_t cfg;
	logic advance;
	logic proc_en;
	logic fsm_emit;
	rsp_t fsm_res;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign proc_en   = req_valid_s1 && advance;
	assign req_stall = req_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall) req_s1 <= req;
	end

	sdspi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sdspi_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (proc_en),
		.item   (req_s1),
		.cfg    (cfg),
		.emit   (fsm_emit),
		.res    (fsm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= proc_en && fsm_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) rsp_q <= fsm_res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
